// File: rtl/core/led_matrix_pwm_pulse_scanner_assert.svh
// Assertion macros shared by the scanner RTL.
`ifndef LED_MATRIX_PWM_PULSE_SCANNER_ASSERT_SVH
`define LED_MATRIX_PWM_PULSE_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LMPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LMPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lmps_pkg.sv
// Types, codes and the PWM threshold table of the LED matrix scanner.
package lmps_pkg;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_PULSE   = 2'd1;
	localparam logic [1:0] MODE_REFRESH = 2'd2;

	localparam logic [7:0] PULSE_THRESHOLD = 8'd40;
	localparam logic [5:0] PWM_LAST_STEP   = 6'd40;
	localparam logic [7:0] PULSE_PEAK_RST  = 8'd40;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] pixel_column;
		logic [2:0] pixel_row;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic [2:0] column_index;
		logic [7:0] row_pattern;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REBUILD,
		ST_FLUSH,
		ST_REFRESH
	} state_t;

	// Scrambled threshold per PWM step; one value appears twice.
	function automatic logic [5:0] pwm_threshold(input logic [5:0] step);
		logic [5:0] thr;
		case (step)
			6'd0:  thr = 6'd0;
			6'd1:  thr = 6'd20;
			6'd2:  thr = 6'd12;
			6'd3:  thr = 6'd32;
			6'd4:  thr = 6'd6;
			6'd5:  thr = 6'd26;
			6'd6:  thr = 6'd23;
			6'd7:  thr = 6'd36;
			6'd8:  thr = 6'd3;
			6'd9:  thr = 6'd16;
			6'd10: thr = 6'd29;
			6'd11: thr = 6'd9;
			6'd12: thr = 6'd24;
			6'd13: thr = 6'd4;
			6'd14: thr = 6'd34;
			6'd15: thr = 6'd14;
			6'd16: thr = 6'd40;
			6'd17: thr = 6'd21;
			6'd18: thr = 6'd1;
			6'd19: thr = 6'd37;
			6'd20: thr = 6'd7;
			6'd21: thr = 6'd11;
			6'd22: thr = 6'd31;
			6'd23: thr = 6'd7;
			6'd24: thr = 6'd27;
			6'd25: thr = 6'd35;
			6'd26: thr = 6'd15;
			6'd27: thr = 6'd25;
			6'd28: thr = 6'd5;
			6'd29: thr = 6'd30;
			6'd30: thr = 6'd10;
			6'd31: thr = 6'd22;
			6'd32: thr = 6'd39;
			6'd33: thr = 6'd2;
			6'd34: thr = 6'd19;
			6'd35: thr = 6'd33;
			6'd36: thr = 6'd13;
			6'd37: thr = 6'd28;
			6'd38: thr = 6'd8;
			6'd39: thr = 6'd18;
			6'd40: thr = 6'd38;
			default: thr = 6'd0;
		endcase
		return thr;
	endfunction

endpackage

// File: rtl/core/led_matrix_pwm_pulse_scanner.sv
// Top level of the column-scanned LED matrix PWM and pulse controller.
//
// One item is taken at a time. A pixel write goes to the pixel store when
// accepted; a refresh reads the shown word, then does the threshold compare
// into the output register, held up only while the previous result still
// waits. A pulse step, ended by a flush state, walks the pixel store, which
// has one read port, one pixel a cycle to rebuild the shown store, one word
// per column. Both stores are cleared at reset through per-entry valid flags,
// so no clearing pass is needed. The pulse_peak register is written through
// the cfg channel, which is always ready.
module led_matrix_pwm_pulse_scanner #(
	parameter int COLUMNS = 5,
	parameter int ROWS    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lmps_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lmps_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	import lmps_pkg::*;

	localparam int PIX_DEPTH = COLUMNS * 8;
	localparam int PIX_AW    = $clog2(PIX_DEPTH);
	localparam int SHW_AW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_IW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SHW_W     = ROWS * 8;
	localparam logic [2:0] LAST_COL = 3'(COLUMNS - 1);
	localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);

	state_t state_q, state_d;

	logic [7:0] pulse_peak_q;
	logic [7:0] pulse_lvl_q;
	logic       pulse_rise_q;
	logic [5:0] pwm_step_q;
	logic [2:0] scan_col_q;

	logic [2:0] col_q;
	logic [2:0] row_q;

	logic                    reb_s1;
	logic [2:0]              col_s1;
	logic [2:0]              row_s1;
	logic                    pix_vld_s1;
	logic                    shw_vld_s1;
	logic [ROWS-1:0][7:0]    asm_q;

	logic [PIX_DEPTH-1:0]    pix_vld_q;
	logic [COLUMNS-1:0]      shw_vld_q;

	logic                    out_valid_q;
	out_item_t               out_item_q;

	logic in_xfer;
	logic wr_pixel;
	logic wr_in_range;
	logic pulse_go;
	logic refresh_go;
	logic reb_issue;
	logic reb_last;
	logic out_load;

	logic [PIX_AW-1:0] pix_wr_addr;
	logic [PIX_AW-1:0] pix_rd_addr;
	logic [7:0]        pix_rd_data;
	logic [7:0]        pix_val;
	logic [7:0]        shown_val;
	logic [ROWS-1:0][7:0] shw_word;
	logic              shw_wr_en;
	logic [SHW_W-1:0]  shw_rd_data;
	logic [SHW_W-1:0]  shw_data;
	logic [7:0]        row_pat;
	logic [7:0]        thr;

	logic [7:0] pulse_lvl_d;
	logic       pulse_rise_d;

	assign cfg_ready   = 1'b1;
	assign in_xfer     = in_valid && in_ready;
	assign wr_in_range = ({1'b0, in_item.pixel_column} < 4'(COLUMNS))
		&& ({1'b0, in_item.pixel_row} < 4'(ROWS));
	assign wr_pixel    = in_xfer && (in_item.mode == MODE_WRITE) && wr_in_range;
	assign pulse_go    = in_xfer && (in_item.mode == MODE_PULSE);
	assign refresh_go  = in_xfer && (in_item.mode == MODE_REFRESH);
	assign reb_last    = (col_q == LAST_COL) && (row_q == LAST_ROW);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pulse_go) begin
					state_d = ST_REBUILD;
				end else if (refresh_go) begin
					state_d = ST_REFRESH;
				end
			end
			ST_REBUILD: begin
				if (reb_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_IDLE;
			ST_REFRESH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready  = 1'b0;
		reb_issue = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:    in_ready  = 1'b1;
			ST_REBUILD: reb_issue = 1'b1;
			ST_FLUSH:   in_ready  = 1'b0;
			ST_REFRESH: out_load  = !out_valid_q || out_ready;
			default:    in_ready  = 1'b0;
		endcase
	end

	// Triangle-wave step of the pulse level
	always_comb begin
		if (pulse_rise_q) begin
			pulse_lvl_d  = (pulse_lvl_q == 8'hFF) ? pulse_lvl_q : pulse_lvl_q + 8'd1;
			pulse_rise_d = !(pulse_lvl_d >= pulse_peak_q);
		end else begin
			pulse_lvl_d  = (pulse_lvl_q == 8'd0) ? pulse_lvl_q : pulse_lvl_q - 8'd1;
			pulse_rise_d = (pulse_lvl_d <= 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pulse_peak_q <= PULSE_PEAK_RST;
			pulse_lvl_q  <= '0;
			pulse_rise_q <= 1'b1;
			pwm_step_q   <= '0;
			scan_col_q   <= '0;
			col_q        <= '0;
			row_q        <= '0;
			reb_s1       <= 1'b0;
			pix_vld_q    <= '0;
			shw_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				pulse_peak_q <= cfg_data;
			end
			if (pulse_go) begin
				pulse_lvl_q  <= pulse_lvl_d;
				pulse_rise_q <= pulse_rise_d;
				col_q        <= '0;
				row_q        <= '0;
			end
			if (reb_issue) begin
				if (row_q == LAST_ROW) begin
					row_q <= '0;
					col_q <= col_q + 3'd1;
				end else begin
					row_q <= row_q + 3'd1;
				end
			end
			reb_s1 <= reb_issue;
			if (wr_pixel) begin
				pix_vld_q[pix_wr_addr] <= 1'b1;
			end
			if (shw_wr_en) begin
				shw_vld_q[col_s1[SHW_AW-1:0]] <= 1'b1;
			end
			if (out_load) begin
				pwm_step_q <= (pwm_step_q >= PWM_LAST_STEP) ? 6'd0 : pwm_step_q + 6'd1;
				scan_col_q <= (scan_col_q == LAST_COL) ? 3'd0 : scan_col_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Rebuild pipeline payload and column word assembly
	always_ff @(posedge clk) begin
		col_s1     <= col_q;
		row_s1     <= row_q;
		pix_vld_s1 <= pix_vld_q[pix_rd_addr];
		if (refresh_go) begin
			shw_vld_s1 <= shw_vld_q[scan_col_q[SHW_AW-1:0]];
		end
		if (reb_s1) begin
			asm_q <= shw_word;
		end
		if (out_load) begin
			out_item_q.column_index <= scan_col_q;
			out_item_q.row_pattern  <= row_pat;
		end
	end

	assign pix_wr_addr = PIX_AW'({in_item.pixel_column, in_item.pixel_row});
	assign pix_rd_addr = PIX_AW'({col_q, row_q});

	lmps_ram #(
		.WIDTH (8),
		.DEPTH (PIX_DEPTH),
		.AW    (PIX_AW)
	) u_pixel_ram (
		.clk     (clk),
		.wr_en   (wr_pixel),
		.wr_addr (pix_wr_addr),
		.wr_data (in_item.level),
		.rd_en   (reb_issue),
		.rd_addr (pix_rd_addr),
		.rd_data (pix_rd_data)
	);

	// Never-written pixels read as zero
	assign pix_val   = pix_vld_s1 ? pix_rd_data : 8'd0;
	assign shown_val = (pix_val > PULSE_THRESHOLD) ? pulse_lvl_q : pix_val;

	always_comb begin
		shw_word = (row_s1 == 3'd0) ? '0 : asm_q;
		shw_word[row_s1[ROW_IW-1:0]] = shown_val;
	end

	assign shw_wr_en = reb_s1 && (row_s1 == LAST_ROW);

	lmps_ram #(
		.WIDTH (SHW_W),
		.DEPTH (COLUMNS),
		.AW    (SHW_AW)
	) u_shown_ram (
		.clk     (clk),
		.wr_en   (shw_wr_en),
		.wr_addr (col_s1[SHW_AW-1:0]),
		.wr_data (shw_word),
		.rd_en   (refresh_go),
		.rd_addr (scan_col_q[SHW_AW-1:0]),
		.rd_data (shw_rd_data)
	);

	assign shw_data = shw_vld_s1 ? shw_rd_data : '0;
	assign thr      = {2'b00, pwm_threshold(pwm_step_q)};

	// Light each row whose shown level exceeds this step's threshold
	always_comb begin
		row_pat = '0;
		for (int r = 0; r < ROWS; r++) begin
			row_pat[r] = thr < shw_data[r*8 +: 8];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`include "led_matrix_pwm_pulse_scanner_assert.svh"

	`LMPS_ASSERT_NEXT(a_refresh_loads, (state_q == ST_REFRESH) && out_load, out_valid_q && (state_q == ST_IDLE), "refresh did not deliver a result")
	`LMPS_ASSERT_NOW(a_scan_in_range, 1'b1, ({1'b0, scan_col_q} < 4'(COLUMNS)) && (pwm_step_q <= PWM_LAST_STEP), "scan column or PWM step out of range")
	`LMPS_ASSERT_NOW(a_rebuild_owned, reb_s1, (state_q == ST_REBUILD) || (state_q == ST_FLUSH), "rebuild data outside a pulse step")
	`LMPS_ASSERT_NEXT(a_flush_ends, state_q == ST_FLUSH, (state_q == ST_IDLE) && !reb_s1, "pulse step did not finish after flush")

endmodule

// File: rtl/core/lmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// Hold the last read word while no read is issued.
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
